// File: rtl/core/pcaa_pkg.sv
package pcaa_pkg;

	// Default build constants
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int PHASE_BITS_DEF    = 16;

	// Datapath widths
	localparam int AMP_W = 31;
	localparam int CMP_W = 32;
	localparam int MAG_W = 40;
	localparam int XW    = 44;
	localparam int ZW    = 33;
	localparam int AW    = 32;

	// CORDIC gain in Q0.32 and angle constants on a 2^32 turn
	localparam logic [31:0] GAIN_Q32     = 32'h9B74_EDA8;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic signed [ZW-1:0] QUARTER_P = 33'sh0_4000_0000;
	localparam logic signed [ZW-1:0] QUARTER_N = -33'sh0_4000_0000;
	localparam logic signed [ZW-1:0] HALF_P    = 33'sh0_8000_0000;
	localparam logic [AMP_W-1:0] AMP_MAX   = 31'h7FFF_FFFF;

	// Opcode values
	typedef enum logic {
		OP_POLAR = 1'b0,
		OP_CART  = 1'b1
	} op_t;

	// One classified item between front and back
	typedef struct packed {
		logic                   cart;
		logic [AMP_W-1:0]       base_amp;
		logic                   base_neg;
		logic signed [ZW-1:0]   base_z;
		logic [AMP_W-1:0]       add_amp;
		logic                   add_neg;
		logic signed [ZW-1:0]   add_z;
		logic signed [CMP_W-1:0] add_re;
		logic signed [CMP_W-1:0] add_im;
	} item_t;

	// Arctangent of 2^-i as a fraction of a 2^32 turn
	function automatic logic [AW-1:0] atan_q32(input int i);
		logic [AW-1:0] t;
		unique case (i)
			0:  t = 32'h2000_0000;  1: t = 32'h12E4_051D;
			2:  t = 32'h09FB_385B;  3: t = 32'h0511_11D4;
			4:  t = 32'h028B_0D43;  5: t = 32'h0145_D7E1;
			6:  t = 32'h00A2_F61E;  7: t = 32'h0051_7C55;
			8:  t = 32'h0028_BE53;  9: t = 32'h0014_5F2E;
			10: t = 32'h000A_2F98; 11: t = 32'h0005_17CC;
			12: t = 32'h0002_8BE6; 13: t = 32'h0001_45F3;
			14: t = 32'h0000_A2F9; 15: t = 32'h0000_517C;
			16: t = 32'h0000_28BE; 17: t = 32'h0000_145F;
			18: t = 32'h0000_0A2F; 19: t = 32'h0000_0517;
			20: t = 32'h0000_028B; 21: t = 32'h0000_0145;
			22: t = 32'h0000_00A2; 23: t = 32'h0000_0051;
			24: t = 32'h0000_0028; 25: t = 32'h0000_0014;
			26: t = 32'h0000_000A; 27: t = 32'h0000_0005;
			28: t = 32'h0000_0002; 29: t = 32'h0000_0001;
			default: t = 32'h0000_0000;
		endcase
		return t;
	endfunction

endpackage

// File: rtl/core/pcaa_front.sv
module pcaa_front #(
	parameter int PHASE_BITS = pcaa_pkg::PHASE_BITS_DEF
) (
	input  logic                          opcode,
	input  logic [pcaa_pkg::AMP_W-1:0]    base_amp,
	input  logic [PHASE_BITS-1:0]         base_phase,
	input  logic [pcaa_pkg::AMP_W-1:0]    add_amp,
	input  logic [PHASE_BITS-1:0]         add_phase,
	input  logic [pcaa_pkg::CMP_W-1:0]    add_re,
	input  logic [pcaa_pkg::CMP_W-1:0]    add_im,
	output pcaa_pkg::item_t               item
);

	localparam int SH = 32 - PHASE_BITS;

	logic signed [pcaa_pkg::ZW-1:0] bz_raw, az_raw;
	logic [31:0] ba, aa;

	// Scale phases to a 2^32 turn
	always_comb begin
		ba = 32'(base_phase) << SH;
		aa = 32'(add_phase) << SH;
		bz_raw = signed'({ba[31], ba});
		az_raw = signed'({aa[31], aa});
	end

	// Fold angles beyond a quarter turn by a half turn and classify the addend
	always_comb begin
		item.cart     = (pcaa_pkg::op_t'(opcode) == pcaa_pkg::OP_CART);
		item.base_amp = base_amp;
		item.add_amp  = add_amp;
		item.add_re   = signed'(add_re);
		item.add_im   = signed'(add_im);
		priority if (bz_raw > pcaa_pkg::QUARTER_P) begin
			item.base_neg = 1'b1;
			item.base_z   = bz_raw - pcaa_pkg::HALF_P;
		end else if (bz_raw < pcaa_pkg::QUARTER_N) begin
			item.base_neg = 1'b1;
			item.base_z   = bz_raw + pcaa_pkg::HALF_P;
		end else begin
			item.base_neg = 1'b0;
			item.base_z   = bz_raw;
		end
		priority if (az_raw > pcaa_pkg::QUARTER_P) begin
			item.add_neg = 1'b1;
			item.add_z   = az_raw - pcaa_pkg::HALF_P;
		end else if (az_raw < pcaa_pkg::QUARTER_N) begin
			item.add_neg = 1'b1;
			item.add_z   = az_raw + pcaa_pkg::HALF_P;
		end else begin
			item.add_neg = 1'b0;
			item.add_z   = az_raw;
		end
	end

endmodule

// File: rtl/core/pcaa_queue.sv
module pcaa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  pcaa_pkg::item_t wdata,
	output logic            full,
	input  logic            rd,
	output logic            rvalid,
	output pcaa_pkg::item_t rdata
);

	pcaa_pkg::item_t mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign rvalid = (cnt_q != 2'd0);
	assign rdata  = mem_q[rptr_q];

	// Hold classified beats until the back end takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr) wptr_q <= ~wptr_q;
			if (rd) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wdata;
	end

endmodule

// File: rtl/core/pcaa_back.sv
module pcaa_back #(
	parameter int CORDIC_STAGES = pcaa_pkg::CORDIC_STAGES_DEF,
	parameter int PHASE_BITS    = pcaa_pkg::PHASE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  pcaa_pkg::item_t            in_item,
	output logic                       in_take,
	output logic                       empty,
	input  logic                       pop,
	output logic [pcaa_pkg::AMP_W-1:0] sum_amp,
	output logic [PHASE_BITS-1:0]      sum_phase,
	output logic                       amp_saturated
);

	localparam int CS = CORDIC_STAGES;
	localparam int XW = pcaa_pkg::XW;
	localparam int ZW = pcaa_pkg::ZW;
	localparam int AW = pcaa_pkg::AW;
	localparam int SH = 32 - PHASE_BITS;

	logic adv;
	logic out_v_q;

	// Whole pipeline advances while the output slot is free or being drained
	assign adv     = !out_v_q || pop;
	assign in_take = adv && in_valid;
	assign empty   = !out_v_q;

	// Stage 1: prescale polar amplitudes by the CORDIC gain
	logic                    v_s1, cart_s1, bneg_s1, aneg_s1;
	logic [pcaa_pkg::MAG_W-1:0] bm_s1, am_s1;
	logic signed [ZW-1:0]    bz_s1, az_s1;
	logic signed [31:0]      re_s1, im_s1;
	logic [62:0] bprod, aprod;

	always_comb begin
		bprod = 63'(in_item.base_amp) * 63'(pcaa_pkg::GAIN_Q32) + 63'(1 << 23);
		aprod = 63'(in_item.add_amp) * 63'(pcaa_pkg::GAIN_Q32) + 63'(1 << 23);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bm_s1   <= pcaa_pkg::MAG_W'(bprod[62:24]);
			am_s1   <= pcaa_pkg::MAG_W'(aprod[62:24]);
			bneg_s1 <= in_item.base_neg;
			aneg_s1 <= in_item.add_neg;
			bz_s1   <= in_item.base_z;
			az_s1   <= in_item.add_z;
			cart_s1 <= in_item.cart;
			re_s1   <= in_item.add_re;
			im_s1   <= in_item.add_im;
		end
	end

	// Rotation pipeline, base and addend lanes side by side
	logic                 rv_s   [CS];
	logic                 rc_s   [CS];
	logic signed [XW-1:0] rbx_s  [CS];
	logic signed [XW-1:0] rby_s  [CS];
	logic signed [ZW-1:0] rbz_s  [CS];
	logic signed [XW-1:0] rax_s  [CS];
	logic signed [XW-1:0] ray_s  [CS];
	logic signed [ZW-1:0] raz_s  [CS];
	logic signed [31:0]   rre_s  [CS];
	logic signed [31:0]   rim_s  [CS];

	logic signed [XW-1:0] bx0, ax0;

	always_comb begin
		bx0 = bneg_s1 ? -signed'(XW'(bm_s1)) : signed'(XW'(bm_s1));
		ax0 = aneg_s1 ? -signed'(XW'(am_s1)) : signed'(XW'(am_s1));
	end

	for (genvar i = 0; i < CS; i++) begin : g_rot
		logic                 sv, sc;
		logic signed [XW-1:0] sbx, sby, sax, say;
		logic signed [ZW-1:0] sbz, saz;
		logic signed [31:0]   sre, sim;
		logic signed [ZW-1:0] t;

		if (i == 0) begin : g_src0
			assign sv = v_s1;   assign sc = cart_s1;
			assign sbx = bx0;   assign sby = '0; assign sbz = bz_s1;
			assign sax = ax0;   assign say = '0; assign saz = az_s1;
			assign sre = re_s1; assign sim = im_s1;
		end else begin : g_srcn
			assign sv = rv_s[i-1];   assign sc = rc_s[i-1];
			assign sbx = rbx_s[i-1]; assign sby = rby_s[i-1]; assign sbz = rbz_s[i-1];
			assign sax = rax_s[i-1]; assign say = ray_s[i-1]; assign saz = raz_s[i-1];
			assign sre = rre_s[i-1]; assign sim = rim_s[i-1];
		end

		assign t = signed'(ZW'(pcaa_pkg::atan_q32(i)));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rv_s[i] <= 1'b0;
			else if (adv) rv_s[i] <= sv;
		end

		// Rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (adv) begin
				rc_s[i]  <= sc;
				rre_s[i] <= sre;
				rim_s[i] <= sim;
				if (sbz >= 0) begin
					rbx_s[i] <= sbx - (sby >>> i);
					rby_s[i] <= sby + (sbx >>> i);
					rbz_s[i] <= sbz - t;
				end else begin
					rbx_s[i] <= sbx + (sby >>> i);
					rby_s[i] <= sby - (sbx >>> i);
					rbz_s[i] <= sbz + t;
				end
				if (saz >= 0) begin
					rax_s[i] <= sax - (say >>> i);
					ray_s[i] <= say + (sax >>> i);
					raz_s[i] <= saz - t;
				end else begin
					rax_s[i] <= sax + (say >>> i);
					ray_s[i] <= say - (sax >>> i);
					raz_s[i] <= saz + t;
				end
			end
		end
	end

	// Stage 3: add the parts, flag an exact zero sum
	logic                 v_s3, zero_s3;
	logic signed [XW-1:0] sx_s3, sy_s3;
	logic signed [XW-1:0] addx, addy, sumx, sumy;

	always_comb begin
		if (rc_s[CS-1]) begin
			addx = XW'(rre_s[CS-1]) <<< 8;
			addy = XW'(rim_s[CS-1]) <<< 8;
		end else begin
			addx = rax_s[CS-1];
			addy = ray_s[CS-1];
		end
		sumx = rbx_s[CS-1] + addx;
		sumy = rby_s[CS-1] + addy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= rv_s[CS-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s3   <= sumx;
			sy_s3   <= sumy;
			zero_s3 <= (sumx == '0) && (sumy == '0);
		end
	end

	// Vectoring pipeline
	logic                 vv_s [CS];
	logic                 vz0_s[CS];
	logic signed [XW-1:0] vx_s [CS];
	logic signed [XW-1:0] vy_s [CS];
	logic [AW-1:0]        vz_s [CS];

	logic signed [XW-1:0] x0, y0;
	logic [AW-1:0]        z0;

	// Fold a negative real part by a half turn
	always_comb begin
		if (sx_s3 < 0) begin
			x0 = -sx_s3;
			y0 = -sy_s3;
			z0 = pcaa_pkg::HALF_TURN;
		end else begin
			x0 = sx_s3;
			y0 = sy_s3;
			z0 = '0;
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_vec
		logic                 sv, szero;
		logic signed [XW-1:0] sx, sy;
		logic [AW-1:0]        sz;
		logic [AW-1:0]        t;

		if (i == 0) begin : g_src0
			assign sv = v_s3; assign szero = zero_s3;
			assign sx = x0;   assign sy = y0; assign sz = z0;
		end else begin : g_srcn
			assign sv = vv_s[i-1]; assign szero = vz0_s[i-1];
			assign sx = vx_s[i-1]; assign sy = vy_s[i-1]; assign sz = vz_s[i-1];
		end

		assign t = pcaa_pkg::atan_q32(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vv_s[i] <= 1'b0;
			else if (adv) vv_s[i] <= sv;
		end

		// Drive the imaginary part toward zero
		always_ff @(posedge clk) begin
			if (adv) begin
				vz0_s[i] <= szero;
				if (sy >= 0) begin
					vx_s[i] <= sx + (sy >>> i);
					vy_s[i] <= sy - (sx >>> i);
					vz_s[i] <= sz + t;
				end else begin
					vx_s[i] <= sx - (sy >>> i);
					vy_s[i] <= sy + (sx >>> i);
					vz_s[i] <= sz - t;
				end
			end
		end
	end

	// Stage 5: remove the gain in two partial products
	logic                 v_s5, zero_s5;
	logic [59:0]          hi_s5;
	logic [47:0]          lo_s5;
	logic [AW-1:0]        z_s5;
	logic [XW-1:0]        ux;

	assign ux = (vx_s[CS-1] < 0) ? '0 : unsigned'(vx_s[CS-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= vv_s[CS-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hi_s5   <= 60'(ux[XW-1:16]) * 60'(pcaa_pkg::GAIN_Q32);
			lo_s5   <= 48'(ux[15:0]) * 48'(pcaa_pkg::GAIN_Q32);
			z_s5    <= vz_s[CS-1];
			zero_s5 <= vz0_s[CS-1];
		end
	end

	// Round, saturate and reduce the phase into the output slot
	logic [48:0] lo_r;
	logic [60:0] mag_sum;
	logic [36:0] mag;
	logic [32:0] ph_sum;

	always_comb begin
		lo_r    = 49'(lo_s5) + (49'(1) << 39);
		mag_sum = 61'(hi_s5) + 61'(lo_r >> 16);
		mag     = mag_sum[24 +: 37];
		ph_sum  = {1'b0, z_s5} + ((33'(1) << SH) >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_s5) begin
				sum_amp       <= '0;
				sum_phase     <= '0;
				amp_saturated <= 1'b0;
			end else begin
				sum_phase <= ph_sum[SH +: PHASE_BITS];
				if (mag > 37'(pcaa_pkg::AMP_MAX)) begin
					sum_amp       <= pcaa_pkg::AMP_MAX;
					amp_saturated <= 1'b1;
				end else begin
					sum_amp       <= mag[pcaa_pkg::AMP_W-1:0];
					amp_saturated <= 1'b0;
				end
			end
		end
	end

endmodule

// File: rtl/core/polar_complex_accumulate_add_core.sv
// Channel  | Direction | Handshake   | Beat
// ---------+-----------+-------------+--------------------------------------------
// input    | in        | push / full | opcode, base_amp/phase, add_amp/phase/re/im
// result   | out       | empty / pop | sum_amp, sum_phase, amp_saturated
//
// One beat is taken every cycle while full is low; each result is registered through
// stage 1, the two unrolled CORDIC pipelines, stages 3 and 5 and the output slot.
// A two-beat queue parts the input side from the CORDIC pipeline, so push
// goes on until the queue is full while a result waits on pop; the pipeline holds while the
// output slot is full and not popped.
// arst_n clears all valid bits; there is no clearing pass.
module polar_complex_accumulate_add_core #(
	parameter int CORDIC_STAGES = pcaa_pkg::CORDIC_STAGES_DEF,
	parameter int PHASE_BITS    = pcaa_pkg::PHASE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       opcode,
	input  logic [pcaa_pkg::AMP_W-1:0] base_amp,
	input  logic [PHASE_BITS-1:0]      base_phase,
	input  logic [pcaa_pkg::AMP_W-1:0] add_amp,
	input  logic [PHASE_BITS-1:0]      add_phase,
	input  logic [pcaa_pkg::CMP_W-1:0] add_re,
	input  logic [pcaa_pkg::CMP_W-1:0] add_im,
	output logic                       empty,
	input  logic                       pop,
	output logic [pcaa_pkg::AMP_W-1:0] sum_amp,
	output logic [PHASE_BITS-1:0]      sum_phase,
	output logic                       amp_saturated
);

	pcaa_pkg::item_t fr_item, q_item;
	logic q_valid, q_take;

	// Classify and fold the incoming beat
	pcaa_front #(.PHASE_BITS(PHASE_BITS)) u_front (
		.opcode     (opcode),
		.base_amp   (base_amp),
		.base_phase (base_phase),
		.add_amp    (add_amp),
		.add_phase  (add_phase),
		.add_re     (add_re),
		.add_im     (add_im),
		.item       (fr_item)
	);

	pcaa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push && !full),
		.wdata  (fr_item),
		.full   (full),
		.rd     (q_take),
		.rvalid (q_valid),
		.rdata  (q_item)
	);

	pcaa_back #(
		.CORDIC_STAGES (CORDIC_STAGES),
		.PHASE_BITS    (PHASE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (q_valid),
		.in_item       (q_item),
		.in_take       (q_take),
		.empty         (empty),
		.pop           (pop),
		.sum_amp       (sum_amp),
		.sum_phase     (sum_phase),
		.amp_saturated (amp_saturated)
	);

endmodule

// File: tb/sv/polar_complex_accumulate_add_core_tb.sv
module polar_complex_accumulate_add_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = 16;
	localparam int PB = 16;
	localparam int AMP_W = pcaa_pkg::AMP_W;
	localparam int CMP_W = pcaa_pkg::CMP_W;
	localparam logic [31:0] GAIN_Q32 = pcaa_pkg::GAIN_Q32;
	localparam logic [AMP_W-1:0] AMP_MAX = pcaa_pkg::AMP_MAX;
	localparam int N_RANDOM = 1800;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint HALF_T = 64'sd2147483648;
	localparam longint QUARTER_T = 64'sd1073741824;
	localparam longint FULL_T = 64'sd4294967296;

	typedef struct {
		logic [AMP_W-1:0] amp;
		logic [PB-1:0]    phase;
		logic             sat;
	} polar_sum_t;

	typedef struct {
		pcaa_pkg::op_t    op;
		logic [AMP_W-1:0] b_amp;
		logic [PB-1:0]    b_ph;
		logic [AMP_W-1:0] a_amp;
		logic [PB-1:0]    a_ph;
		logic [CMP_W-1:0] a_re;
		logic [CMP_W-1:0] a_im;
		logic             fixed;
		polar_sum_t       res;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full, empty, amp_saturated;
	logic pop = 1'b0;
	logic opcode = 1'b0;
	logic [AMP_W-1:0] base_amp = '0, add_amp = '0, sum_amp;
	logic [PB-1:0] base_phase = '0, add_phase = '0, sum_phase;
	logic [CMP_W-1:0] add_re = '0, add_im = '0;

	polar_sum_t sum_queue[$];
	vec_row_t vectors[$];
	int errors = 0;
	longint cycles = 0;
	bit no_idle = 1'b0;

	always #2 clk = ~clk;

	polar_complex_accumulate_add_core u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.base_amp(base_amp), .base_phase(base_phase), .add_amp(add_amp),
		.add_phase(add_phase), .add_re(add_re), .add_im(add_im), .empty(empty),
		.pop(pop), .sum_amp(sum_amp), .sum_phase(sum_phase),
		.amp_saturated(amp_saturated)
	);

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint angle_of(logic [PB-1:0] ph);
		logic [31:0] a;
		a = {ph, {(32-PB){1'b0}}};
		return a[31] ? longint'(a) - FULL_T : longint'(a);
	endfunction

	function automatic logic [31:0] atan_tab(int i);
		logic [31:0] tab [0:15] = '{32'h20000000, 32'h12E4051D, 32'h09FB385B,
			32'h051111D4, 32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC, 32'h00028BE6,
			32'h000145F3, 32'h0000A2F9, 32'h0000517C};
		return tab[i];
	endfunction

	// prescale an amplitude and rotate it to its phase
	task automatic rotate(input logic [AMP_W-1:0] amp, input logic [PB-1:0] ph,
			output longint xo, output longint yo);
		longint x, y, z, dx, dy, t;
		x = longint'((64'(amp) * 64'(GAIN_Q32) + (64'd1 << 23)) >> 24);
		y = 0;
		z = angle_of(ph);
		if (z > QUARTER_T) begin
			x = -x; z -= HALF_T;
		end else if (z < -QUARTER_T) begin
			x = -x; z += HALF_T;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			t = longint'(atan_tab(i));
			if (z >= 0) begin
				x -= dx; y += dy; z -= t;
			end else begin
				x += dx; y -= dy; z += t;
			end
		end
		xo = x;
		yo = y;
	endtask

	task automatic predict_sum(input vec_row_t r, output polar_sum_t s);
		longint bx, by, ax, ay, x, y, z, dx, dy, t;
		logic [63:0] ux, hi, lo, mag, zu;
		rotate(r.b_amp, r.b_ph, bx, by);
		if (r.op == pcaa_pkg::OP_POLAR) begin
			rotate(r.a_amp, r.a_ph, ax, ay);
		end else begin
			ax = longint'($signed(r.a_re)) * 256;
			ay = longint'($signed(r.a_im)) * 256;
		end
		x = bx + ax;
		y = by + ay;
		s = '{amp: '0, phase: '0, sat: 1'b0};
		if (x == 0 && y == 0) return;
		z = 0;
		if (x < 0) begin
			x = -x; y = -y; z = HALF_T;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			t = longint'(atan_tab(i));
			if (y >= 0) begin
				x += dx; y -= dy; z += t;
			end else begin
				x -= dx; y += dy; z -= t;
			end
		end
		ux = x < 0 ? 64'd0 : 64'(x);
		hi = (ux >> 16) * 64'(GAIN_Q32);
		lo = (ux & 64'hFFFF) * 64'(GAIN_Q32);
		mag = (hi + ((lo + (64'd1 << 39)) >> 16)) >> 24;
		if (mag > 64'(AMP_MAX)) begin
			mag = 64'(AMP_MAX); s.sat = 1'b1;
		end
		zu = 64'(z) & 64'hFFFF_FFFF;
		s.amp = mag[AMP_W-1:0];
		s.phase = PB'((zu + (64'd1 << (31 - PB))) >> (32 - PB));
	endtask

	function automatic vec_row_t mk(pcaa_pkg::op_t op, logic [AMP_W-1:0] ba,
			logic [PB-1:0] bp, logic [AMP_W-1:0] aa, logic [PB-1:0] ap,
			logic [CMP_W-1:0] re, logic [CMP_W-1:0] im);
		vec_row_t r;
		r = '{op: op, b_amp: ba, b_ph: bp, a_amp: aa, a_ph: ap, a_re: re, a_im: im,
			fixed: 1'b0, res: '{amp: '0, phase: '0, sat: 1'b0}};
		return r;
	endfunction

	function automatic vec_row_t mk_fixed(vec_row_t r, logic [AMP_W-1:0] amp,
			logic [PB-1:0] ph, logic sat);
		r.fixed = 1'b1;
		r.res = '{amp: amp, phase: ph, sat: sat};
		return r;
	endfunction

	function automatic vec_row_t rand_row();
		vec_row_t r;
		int k;
		k = $urandom_range(0, 9);
		r = mk(pcaa_pkg::op_t'($urandom_range(0, 1)), AMP_W'($urandom), PB'($urandom),
			AMP_W'($urandom), PB'($urandom), $urandom, $urandom);
		// half small amplitudes, sometimes cancelling pairs and extremes
		if (k < 5) begin
			r.b_amp = r.b_amp >> $urandom_range(0, 30);
			r.a_amp = r.a_amp >> $urandom_range(0, 30);
			r.a_re = CMP_W'($signed(r.a_re) >>> $urandom_range(0, 31));
			r.a_im = CMP_W'($signed(r.a_im) >>> $urandom_range(0, 31));
		end else if (k == 5) begin
			r.a_amp = r.b_amp;
			r.a_ph = r.b_ph ^ {1'b1, {(PB-1){1'b0}}};
		end else if (k == 6) begin
			r.b_amp = AMP_MAX - AMP_W'($urandom_range(0, 255));
			r.a_amp = AMP_MAX - AMP_W'($urandom_range(0, 255));
		end
		return r;
	endfunction

	// drive one beat and hold it until taken
	task automatic send_beat(input vec_row_t r);
		polar_sum_t s;
		while (!no_idle && $urandom_range(0, 99) < 16) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		opcode <= r.op;
		base_amp <= r.b_amp;
		base_phase <= r.b_ph;
		add_amp <= r.a_amp;
		add_phase <= r.a_ph;
		add_re <= r.a_re;
		add_im <= r.a_im;
		@(posedge clk);
		while (full) @(posedge clk);
		if (r.fixed) s = r.res;
		else predict_sum(r, s);
		sum_queue.push_back(s);
		@(negedge clk);
	endtask

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		polar_sum_t e;
		if (arst_n && pop && !empty) begin
			if (sum_queue.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = sum_queue.pop_front();
				if (sum_amp !== e.amp) begin
					$error("sum_amp expected %h actual %h", e.amp, sum_amp);
					errors++;
				end
				if (sum_phase !== e.phase) begin
					$error("sum_phase expected %h actual %h", e.phase, sum_phase);
					errors++;
				end
				if (amp_saturated !== e.sat) begin
					$error("amp_saturated expected %b actual %b", e.sat, amp_saturated);
					errors++;
				end
			end
		end
	end

	// randomly stall the result side
	always @(negedge clk) begin
		pop <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 16);
	end

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int wait_n;
		vectors.push_back(mk_fixed(mk(pcaa_pkg::OP_POLAR, '0, '0, '0, '0, '0, '0),
			'0, '0, 1'b0));
		vectors.push_back(mk_fixed(mk(pcaa_pkg::OP_CART, '0, 16'h1234, '1, '1, '0, '0),
			'0, '0, 1'b0));
		vectors.push_back(mk_fixed(mk(pcaa_pkg::OP_POLAR, AMP_MAX, 16'h0000, AMP_MAX,
			16'h0000, '0, '0), AMP_MAX, '0, 1'b1));
		vectors.push_back(mk(pcaa_pkg::OP_POLAR, 31'h10000, 16'h0000, 31'h10000, 16'h8000,
			'0, '0));
		vectors.push_back(mk(pcaa_pkg::OP_POLAR, 31'h10000, 16'h8000, 31'h10000, 16'h8000,
			'0, '0));
		vectors.push_back(mk(pcaa_pkg::OP_POLAR, 31'h10000, 16'h4000, 31'h20000, 16'hC000,
			'0, '0));
		vectors.push_back(mk(pcaa_pkg::OP_POLAR, 31'h10000, 16'h4001, '0, 16'hBFFF,
			'0, '0));
		vectors.push_back(mk(pcaa_pkg::OP_POLAR, 31'h10000, 16'h7FFF, 31'h1, 16'h8001,
			'0, '0));
		vectors.push_back(mk(pcaa_pkg::OP_CART, 31'h0, '0, '1, '1, 32'hFFFF0000, 32'h0));
		vectors.push_back(mk(pcaa_pkg::OP_CART, '0, '0, '0, '0, 32'h80000000,
			32'h80000000));
		vectors.push_back(mk(pcaa_pkg::OP_CART, '0, '0, '0, '0, 32'h7FFFFFFF,
			32'h7FFFFFFF));
		vectors.push_back(mk(pcaa_pkg::OP_CART, '0, '0, '0, '0, 32'h80000000,
			32'h7FFFFFFF));
		vectors.push_back(mk(pcaa_pkg::OP_CART, AMP_MAX, 16'h8000, '0, '0, 32'h80000000,
			32'h0));
		vectors.push_back(mk(pcaa_pkg::OP_CART, AMP_MAX, 16'h2000, '1, '1, 32'h7FFFFFFF,
			32'hFFFFFFFF));
		vectors.push_back(mk(pcaa_pkg::OP_CART, 31'h1, 16'h0001, '0, '0, 32'h1,
			32'hFFFFFFFF));
		vectors.push_back(mk(pcaa_pkg::OP_POLAR, '1, 16'hFFFF, '1, 16'h7FFF, '1, '1));
		vectors.push_back(mk(pcaa_pkg::OP_POLAR, 31'h55555555, 16'h5555, 31'h2AAAAAAA,
			16'hAAAA, 32'h55555555, 32'hAAAAAAAA));
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (vectors[i]) send_beat(vectors[i]);
		for (int n = 0; n < N_RANDOM; n++) begin
			no_idle = (n >= 600 && n < 900);
			send_beat(rand_row());
		end
		no_idle = 1'b0;
		push <= 1'b0;
		while (sum_queue.size() != 0) @(posedge clk);
		wait_n = 2 * STAGES + 8;
		repeat (wait_n) @(posedge clk);
		if (errors == 0 && sum_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
